/* hdl/lpc_pkg.sv */
// package: cordic table, constants and shared types for the lidar point converter
`timescale 1ns / 1ps
`default_nettype none
package lpc_pkg;
	localparam int CORDIC_STEPS = 20;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN_INIT = 34'sd652032874;

	// configuration register indexes
	localparam logic [7:0] REG_SCAN_START = 8'd0;
	localparam logic [7:0] REG_SCAN_STEP = 8'd1;

	typedef logic signed [CW-1:0] cw_t;

	function automatic cw_t atan_val(input int i);
		cw_t r;
		r = '0;
		case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004757;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41722;
			15: r = 34'sd20861;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2608;
			19: r = 34'sd1304;
			default: r = '0;
		endcase
		return r;
	endfunction

	// one rotation vector travelling down the chain
	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
		logic [1:0] quad;
	} rot_t;
endpackage
`default_nettype wire

/* hdl/lpc_if.sv */
// valid/ready stream interface
`timescale 1ns / 1ps
`default_nettype none
interface lpc_if #(parameter int W = 8) (input wire logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/lpc_cordic_cell.sv */
// one cordic micro-rotation stage, registered
`timescale 1ns / 1ps
`default_nettype none
module lpc_cordic_cell #(
	parameter int STEP = 0
) (
	input wire logic clk,
	input wire logic en,
	input wire lpc_pkg::rot_t rin,
	output lpc_pkg::rot_t rout
);
	lpc_pkg::rot_t nxt;
	lpc_pkg::cw_t dx, dy;
	always_comb begin
		dx = rin.y >>> STEP;
		dy = rin.x >>> STEP;
		nxt = rin;
		if (!rin.z[lpc_pkg::CW-1]) begin
			nxt.x = rin.x - dx;
			nxt.y = rin.y + dy;
			nxt.z = rin.z - lpc_pkg::atan_val(STEP);
		end else begin
			nxt.x = rin.x + dx;
			nxt.y = rin.y - dy;
			nxt.z = rin.z + lpc_pkg::atan_val(STEP);
		end
	end
	always_ff @(posedge clk) begin
		if (en) rout <= nxt;
	end
endmodule
`default_nettype wire

/* hdl/lpc_sincos.sv */
// pipelined sine/cosine: quadrant split, chain of cordic cells, rounding to q.15
`timescale 1ns / 1ps
`default_nettype none
module lpc_sincos #(
	parameter int ANGLE_BITS = 16
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [ANGLE_BITS-1:0] ang,
	output logic signed [16:0] cos15,
	output logic signed [16:0] sin15
);
	localparam int N = lpc_pkg::CORDIC_STEPS;
	lpc_pkg::rot_t chain [0:N];
	logic [31:0] a, rr;
	logic [1:0] q;
	lpc_pkg::cw_t c, s, cr, sr;

	always_comb begin
		a = {ang, {(32-ANGLE_BITS){1'b0}}};
		q = 2'(((a + 32'h2000_0000) >> 30));
		rr = a - {q, 30'd0};
		chain[0].x = lpc_pkg::CORDIC_GAIN_INIT;
		chain[0].y = '0;
		chain[0].z = lpc_pkg::CW'(signed'(rr));
		chain[0].quad = q;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		lpc_cordic_cell #(.STEP(i)) u_cell (
			.clk(clk), .en(en), .rin(chain[i]), .rout(chain[i+1])
		);
	end

	always_comb begin
		case (chain[N].quad)
			2'd0: begin c = chain[N].x; s = chain[N].y; end
			2'd1: begin c = -chain[N].y; s = chain[N].x; end
			2'd2: begin c = -chain[N].x; s = -chain[N].y; end
			default: begin c = chain[N].y; s = -chain[N].x; end
		endcase
		cr = (c + lpc_pkg::CW'(16384)) >>> 15;
		sr = (s + lpc_pkg::CW'(16384)) >>> 15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos15 <= 17'(cr);
			sin15 <= 17'(sr);
		end
	end
endmodule
`default_nettype wire

/* hdl/lidar_polar_to_cartesian.sv */
// top level: lidar polar range samples to cartesian points
// throughput: one item per cycle; the whole datapath is a stalled-together pipeline
// stages: 20 cordic cells (angle prep feeds the first), rounding, products, scale, saturation
// reset: arst_n clears valid bits, config registers and the stored scan angle at once;
// datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module lidar_polar_to_cartesian #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16,
	parameter int INDEX_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	lpc_if.sink in_ch,
	lpc_if.sink cfg,
	lpc_if.source out_ch
);
	// in_ch.data = {last_in_scan, rotor_position, beam_index, range}
	// cfg.data = {index[7:0], value[15:0]}
	// out_ch.data = {cloud_complete, pos_z, pos_y, pos_x}
	localparam int LAT = lpc_pkg::CORDIC_STEPS + 4;

	logic [15:0] start_q, step_q;
	logic [ANGLE_BITS-1:0] prev_q;
	logic en;
	logic [LAT-1:0] vld_q;

	// pipeline moves whenever the output slot is free or its result is taken
	assign en = out_ch.ready || !vld_q[LAT-1];
	assign in_ch.ready = en;
	assign cfg.ready = 1'b1;
	assign out_ch.valid = vld_q[LAT-1];

	// unknown register indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.data[23:16])
				lpc_pkg::REG_SCAN_START: start_q <= cfg.data[15:0];
				lpc_pkg::REG_SCAN_STEP: step_q <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
	end

	// angle prep (combinational): elevation and wrapped rotor angle
	logic [15:0] rng;
	logic [11:0] bidx;
	logic [31:0] rot;
	logic last;
	assign rng = in_ch.data[15:0];
	assign bidx = in_ch.data[27:16];
	assign rot = in_ch.data[59:28];
	assign last = in_ch.data[60];

	logic signed [31:0] prod_idx;
	logic [ANGLE_BITS-1:0] theta, phi;
	always_comb begin
		prod_idx = signed'({1'b0, 31'(bidx[INDEX_BITS-1:0])}) * 32'(signed'(step_q));
		theta = ANGLE_BITS'(32'(1 << (ANGLE_BITS - 2)) - 32'(signed'(start_q)) - prod_idx);
		phi = rot[ANGLE_BITS-1:0];
	end

	// cloud completion decided at input, state updated in order
	logic [ANGLE_BITS:0] dpos;
	logic done;
	always_comb begin
		dpos = (phi >= prev_q) ? {1'b0, phi - prev_q} : {1'b0, prev_q - phi};
		done = last && (dpos > (ANGLE_BITS+1)'(1 << (ANGLE_BITS - 1)));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) prev_q <= '0;
		else if (en && in_ch.valid && last) prev_q <= phi;
	end

	// sideband delay line for range and done
	logic [RANGE_BITS-1:0] rng_d [0:lpc_pkg::CORDIC_STEPS];
	logic done_d [0:LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			rng_d[0] <= RANGE_BITS'(rng);
			done_d[0] <= done;
			for (int i = 1; i <= lpc_pkg::CORDIC_STEPS; i++) rng_d[i] <= rng_d[i-1];
			for (int i = 1; i < LAT; i++) done_d[i] <= done_d[i-1];
		end
	end

	logic signed [16:0] ct, st, cp, sp;
	lpc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_theta (
		.clk(clk), .en(en), .ang(theta), .cos15(ct), .sin15(st)
	);
	lpc_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_phi (
		.clk(clk), .en(en), .ang(phi), .cos15(cp), .sin15(sp)
	);

	// products: r*sin(theta), r*cos(theta), sin(theta) parts
	localparam int PW = RANGE_BITS + 18;

	function automatic logic signed [RANGE_BITS+1:0] sat(input logic signed [PW+17:0] v);
		logic signed [PW+17:0] lim;
		lim = (PW+18)'((64'd1 << RANGE_BITS) - 1);
		if (v > lim) return (RANGE_BITS+2)'(lim);
		if (v < -lim) return (RANGE_BITS+2)'(-lim);
		return (RANGE_BITS+2)'(v);
	endfunction

	logic signed [PW-1:0] rst_s1, rct_s1;
	logic signed [16:0] cp_s1, sp_s1;
	logic signed [PW+17:0] xp_s2, yp_s2;
	logic signed [PW-1:0] zp_s2;
	logic signed [RANGE_BITS+1:0] x_s3, y_s3, z_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			rst_s1 <= signed'({1'b0, rng_d[lpc_pkg::CORDIC_STEPS]}) * st;
			rct_s1 <= signed'({1'b0, rng_d[lpc_pkg::CORDIC_STEPS]}) * ct;
			cp_s1 <= cp;
			sp_s1 <= sp;
			xp_s2 <= (rst_s1 * cp_s1 + (PW+18)'(1 << 29)) >>> 30;
			yp_s2 <= (rst_s1 * sp_s1 + (PW+18)'(1 << 29)) >>> 30;
			zp_s2 <= (rct_s1 + PW'(1 << 14)) >>> 15;
			x_s3 <= sat(xp_s2);
			y_s3 <= sat(yp_s2);
			z_s3 <= sat((PW+18)'(zp_s2));
		end
	end

	logic signed [16:0] ox, oy, oz;
	assign ox = 17'(x_s3);
	assign oy = 17'(y_s3);
	assign oz = 17'(z_s3);
	assign out_ch.data = {done_d[LAT-1], oz, oy, ox};
	// upper turns of the rotor angle drop out on wrapping
	logic unused;
	assign unused = ^rot[31:ANGLE_BITS];
endmodule
`default_nettype wire

/* hdl/lpc_checker.sv */
// port-level checks for the lidar point converter
`timescale 1ns / 1ps
`default_nettype none
module lpc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic in_ready,
	input wire logic [51:0] out_data
);
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled with empty output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
	a_zero_when_reset: assert property (@(posedge clk)
		!arst_n |=> !out_valid || arst_n) else $error("valid during reset");
endmodule
bind lidar_polar_to_cartesian lpc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.in_ready(in_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire
